>>> rtl/core/rotary_embedding_rotate_top_assert.svh
// ----------------------------------------------------------------------------
// Rotary embedding rotator: assertion macros
// Shared concurrent assertion forms for the rotator RTL.
// ----------------------------------------------------------------------------
`ifndef ROTARY_EMBEDDING_ROTATE_TOP_ASSERT_SVH
`define ROTARY_EMBEDDING_ROTATE_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RER_ASSERT_HOLDS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// An implication checked in the same cycle.
`define RER_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rer_pkg.sv
// ----------------------------------------------------------------------------
// Rotary embedding rotator package
// Widths, register codes and payload types shared by the rotator modules.
// ----------------------------------------------------------------------------
package rer_pkg;

    localparam int VALUE_BITS      = 16;
    localparam int TRIG_BITS       = 16;
    localparam int TRIG_FRAC       = 14;
    localparam int LEN_W           = 9;
    localparam int INDEX_W         = 8;
    localparam int MAX_LEN_DEFAULT = 256;
    localparam int PROD_W          = VALUE_BITS + TRIG_BITS;
    localparam int SUM_W           = PROD_W + 2;

    // Result queue; the depth must be a power of two.
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_LENGTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_LAYOUT   = 1'b1;

    localparam logic LAYOUT_SPLIT       = 1'b0;
    localparam logic LAYOUT_INTERLEAVED = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(128);

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] elem_value;
        logic signed [TRIG_BITS-1:0]  sine_value;
        logic signed [TRIG_BITS-1:0]  cosine_value;
    } in_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0]           out_index;
        logic signed [VALUE_BITS-1:0] out_value;
        logic                         pair_last;
        logic                         vector_done;
    } out_item_t;

    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] idx0;
        logic [INDEX_W-1:0] idx1;
        logic               done;
    } pair_tag_t;

    typedef struct packed {
        logic prod_busy;
        logic sum_busy;
    } dp_status_t;

endpackage

>>> rtl/core/rer_rotate_dp.sv
// ----------------------------------------------------------------------------
// Rotary embedding rotator: rotation datapath
// Two registered stages of multiply and add, then rounding and saturation.
// ----------------------------------------------------------------------------
module rer_rotate_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rer_pkg::pair_tag_t                   tag_in,
    input  rer_pkg::in_item_t                    a_in,
    input  logic signed [rer_pkg::VALUE_BITS-1:0] x1_in,
    output rer_pkg::dp_status_t                  status,
    output logic                                 push_valid,
    output rer_pkg::out_item_t                   res0,
    output rer_pkg::out_item_t                   res1
);

    localparam int PW = rer_pkg::PROD_W;
    localparam int SW = rer_pkg::SUM_W;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1 << (rer_pkg::TRIG_FRAC - 1));
    localparam logic signed [SW-1:0] SAT_HI     = SW'((1 << (rer_pkg::VALUE_BITS - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO     = ~SAT_HI;

    rer_pkg::pair_tag_t   tag_p_reg, tag_s_reg;
    logic signed [PW-1:0] p_xc_reg, p_x1s_reg, p_xs_reg, p_x1c_reg;
    logic signed [SW-1:0] y0_reg, y1_reg;
    logic signed [SW-1:0] y0_next, y1_next;

    // Round to nearest with ties upward, then clamp to the element range.
    function automatic logic signed [rer_pkg::VALUE_BITS-1:0] round_sat(
        input logic signed [SW-1:0] y
    );
        logic signed [SW-1:0] r;
        r = y >>> rer_pkg::TRIG_FRAC;
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        return r[rer_pkg::VALUE_BITS-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_p_reg.valid <= 1'b0;
            tag_s_reg.valid <= 1'b0;
        end else begin
            tag_p_reg.valid <= tag_in.valid;
            tag_s_reg.valid <= tag_p_reg.valid;
        end
        tag_p_reg.idx0 <= tag_in.idx0;
        tag_p_reg.idx1 <= tag_in.idx1;
        tag_p_reg.done <= tag_in.done;
        tag_s_reg.idx0 <= tag_p_reg.idx0;
        tag_s_reg.idx1 <= tag_p_reg.idx1;
        tag_s_reg.done <= tag_p_reg.done;
        p_xc_reg  <= a_in.elem_value * a_in.cosine_value;
        p_x1s_reg <= x1_in * a_in.sine_value;
        p_xs_reg  <= a_in.elem_value * a_in.sine_value;
        p_x1c_reg <= x1_in * a_in.cosine_value;
        y0_reg    <= y0_next;
        y1_reg    <= y1_next;
    end

    always_comb begin
        y0_next = SW'(p_xc_reg) - SW'(p_x1s_reg) + ROUND_HALF;
        y1_next = SW'(p_xs_reg) + SW'(p_x1c_reg) + ROUND_HALF;
    end

    always_comb begin
        res0.out_index   = tag_s_reg.idx0;
        res0.out_value   = round_sat(y0_reg);
        res0.pair_last   = 1'b0;
        res0.vector_done = 1'b0;
        res1.out_index   = tag_s_reg.idx1;
        res1.out_value   = round_sat(y1_reg);
        res1.pair_last   = 1'b1;
        res1.vector_done = tag_s_reg.done;
    end

    assign push_valid       = tag_s_reg.valid;
    assign status.prod_busy = tag_p_reg.valid;
    assign status.sum_busy  = tag_s_reg.valid;

endmodule

>>> rtl/core/rer_out_fifo.sv
// ----------------------------------------------------------------------------
// Rotary embedding rotator: result queue
// Takes both results of a pair in one cycle and hands out one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module rer_out_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push_valid,
    input  rer_pkg::out_item_t                push0,
    input  rer_pkg::out_item_t                push1,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rer_pkg::out_item_t                m_data,
    output logic [rer_pkg::FIFO_CNT_W-1:0]    count
);

    localparam int PTR_W = rer_pkg::FIFO_PTR_W;
    localparam int CNT_W = rer_pkg::FIFO_CNT_W;

    rer_pkg::out_item_t buf_reg [rer_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               pop;

    assign m_valid = (cnt_reg != '0);
    assign m_data  = buf_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;
    assign count   = cnt_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_valid) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(2);
            cnt_next    = cnt_next + CNT_W'(2);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            cnt_next    = cnt_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            buf_reg[wr_ptr_reg]               <= push0;
            buf_reg[wr_ptr_reg + PTR_W'(1)]   <= push1;
        end
    end

endmodule

>>> rtl/core/rotary_embedding_rotate_top.sv
// ----------------------------------------------------------------------------
// Rotary embedding rotator, top level
// Rotates element pairs of a vector stream by their sine and cosine.
// ----------------------------------------------------------------------------
// Usage:
// Elements of a vector enter on the s_ channel, one per transfer, each with
// the sine and cosine of its pair in Q2.14. Results leave on the m_ channel,
// one per transfer, carrying their position in the vector, the rotated value
// and pair and vector end flags. The item that completes a pair yields two
// results, the first element's rotation first.
// Throughput is one input transfer per cycle while the queue has room. In
// split layout every second-half transfer yields two results against one
// leaving per cycle, so a long second half is paced by the queue draining.
// The first result of a pair passes, in order, through the pair store read,
// the multipliers, the adders and the result queue; the second result of
// the pair leaves the queue right behind it.
// The first-half store is a single-port-write, single-read memory; since one
// element is accepted per cycle, a write and a later read of the same entry
// never fall in the same cycle, so no forwarding is needed.
// When the receiver stalls, results collect in a sixteen-entry queue and
// s_ready falls once the queue and the results still in flight could not
// take another pair. s_ready is low while reset is held. Reset sets the length
// to 128, the split layout and the start of a vector. Writing either register
// also restarts the vector.
// ----------------------------------------------------------------------------
`include "rotary_embedding_rotate_top_assert.svh"

module rotary_embedding_rotate_top #(
    parameter int MAX_LEN = rer_pkg::MAX_LEN_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rer_pkg::in_item_t                    s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rer_pkg::out_item_t                   m_data,
    input  logic                                 cfg_wr_en,
    input  logic [rer_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [rer_pkg::LEN_W-1:0]            cfg_wdata
);

    localparam int LW = rer_pkg::LEN_W;
    localparam int IW = rer_pkg::INDEX_W;
    // The length register cannot exceed its own range, so neither can the store.
    localparam int LEN_LIMIT   = (MAX_LEN < (1 << LW) - 1) ? MAX_LEN : (1 << LW) - 1;
    localparam int STORE_DEPTH = LEN_LIMIT / 2;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam logic [LW-1:0] LEN_LIMIT_C = LW'(LEN_LIMIT);
    localparam int OCC_W = rer_pkg::FIFO_CNT_W + 1;

    // Configuration and position state.
    logic [LW-1:0]     len_reg;
    logic              layout_reg;
    logic [LW-1:0]     count_reg, count_next;

    // First element of an interleaved pair.
    rer_pkg::in_item_t pair_hold_reg;

    // First-half store and its registered read port.
    rer_pkg::in_item_t store_mem [STORE_DEPTH];
    rer_pkg::in_item_t store_rd_reg;

    // Stage registered alongside the store read.
    rer_pkg::pair_tag_t                   tag1_reg;
    logic signed [rer_pkg::VALUE_BITS-1:0] x1_reg;
    logic                                 sel_hold_reg;

    logic [LW-1:0]      len_eff, half, pairs_len, pos, pos_m1, pos_p1, j_pos;
    logic               accept, interleaved, in_pairs, first_half;
    logic               hold_we, store_we, store_re, emit;
    logic [ADDR_W-1:0]  store_waddr, store_raddr;
    rer_pkg::pair_tag_t tag_next;
    rer_pkg::in_item_t  operand;

    rer_pkg::dp_status_t             dp_status;
    logic                            push_valid;
    rer_pkg::out_item_t              res0, res1;
    logic [rer_pkg::FIFO_CNT_W-1:0]  fifo_count;
    logic [1:0]                      busy_stages;
    logic [OCC_W-1:0]                occupancy;

    // Effective length: clamped to the length limit that sizes the store, and a
    // zero length acts as one so that every element is a trailing one.
    always_comb begin
        if (len_reg > LEN_LIMIT_C) begin
            len_eff = LEN_LIMIT_C;
        end else if (len_reg == '0) begin
            len_eff = LW'(1);
        end else begin
            len_eff = len_reg;
        end
        half      = len_eff >> 1;
        pairs_len = {len_eff[LW-1:1], 1'b0};
        pos       = (count_reg >= len_eff) ? '0 : count_reg;
        pos_m1    = pos - LW'(1);
        pos_p1    = pos + LW'(1);
        j_pos     = pos - half;
    end

    assign accept      = s_valid && s_ready;
    assign interleaved = (layout_reg == rer_pkg::LAYOUT_INTERLEAVED);
    assign in_pairs    = (pos < pairs_len);
    assign first_half  = (pos < half);

    // Interleaved layout keeps the even element in a holding register; split
    // layout writes the first half into the store and reads it back when the
    // partner from the second half arrives.
    assign hold_we     = accept && interleaved && in_pairs && !pos[0];
    assign store_we    = accept && !interleaved && first_half;
    assign store_re    = accept && !interleaved && !first_half && in_pairs;
    assign emit        = accept && in_pairs && (interleaved ? pos[0] : !first_half);
    assign store_waddr = pos[ADDR_W-1:0];
    assign store_raddr = j_pos[ADDR_W-1:0];

    always_comb begin
        tag_next.valid = emit;
        tag_next.idx0  = interleaved ? pos_m1[IW-1:0] : j_pos[IW-1:0];
        tag_next.idx1  = pos[IW-1:0];
        tag_next.done  = (pos == pairs_len - LW'(1));
    end

    // The position wraps at the end of a vector; a register write restarts it.
    always_comb begin
        count_next = count_reg;
        if (cfg_wr_en) begin
            count_next = '0;
        end else if (accept) begin
            count_next = (pos_p1 >= len_eff) ? '0 : pos_p1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= rer_pkg::LEN_RESET;
            layout_reg <= rer_pkg::LAYOUT_SPLIT;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    rer_pkg::REG_VECTOR_LENGTH: len_reg    <= cfg_wdata;
                    rer_pkg::REG_PAIR_LAYOUT:   layout_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (hold_we) begin
            pair_hold_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[store_waddr] <= s_data;
        end
        if (store_re) begin
            store_rd_reg <= store_mem[store_raddr];
        end
    end

    // The pipeline never stalls: admission control below guarantees room in
    // the queue for every pair in flight.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg.valid <= 1'b0;
        end else begin
            tag1_reg.valid <= tag_next.valid;
        end
        tag1_reg.idx0 <= tag_next.idx0;
        tag1_reg.idx1 <= tag_next.idx1;
        tag1_reg.done <= tag_next.done;
        x1_reg        <= s_data.elem_value;
        sel_hold_reg  <= interleaved;
    end

    // The holding register cannot be overwritten before the products are
    // taken, as the next even element is written no sooner than they are registered.
    assign operand = sel_hold_reg ? pair_hold_reg : store_rd_reg;

    rer_rotate_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tag_in     (tag1_reg),
        .a_in       (operand),
        .x1_in      (x1_reg),
        .status     (dp_status),
        .push_valid (push_valid),
        .res0       (res0),
        .res1       (res1)
    );

    rer_out_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push0      (res0),
        .push1      (res1),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .count      (fifo_count)
    );

    // Every pair in flight reserves two queue entries; a new transfer is taken
    // only while one more pair would still fit, and never during reset.
    always_comb begin
        busy_stages = {1'b0, tag1_reg.valid} + {1'b0, dp_status.prod_busy}
                    + {1'b0, dp_status.sum_busy};
        occupancy   = OCC_W'(fifo_count) + OCC_W'({busy_stages, 1'b0});
        s_ready     = aresetn && (occupancy <= OCC_W'(rer_pkg::FIFO_DEPTH - 2));
    end

    `RER_ASSERT_HOLDS(a_pos_in_range, aclk, aresetn, count_reg < len_eff,
        "element position has run past the vector length")
    `RER_ASSERT_HOLDS(a_no_overflow, aclk, aresetn,
        occupancy <= OCC_W'(rer_pkg::FIFO_DEPTH),
        "results in flight exceed the result queue")
    `RER_ASSERT_IMPLIES(a_done_is_last, aclk, aresetn, m_valid && m_data.vector_done,
        m_data.pair_last, "vector end flagged on a first-of-pair result")

endmodule
